[rtl/core/serial_line_pwm_configurator_defines.svh]
// Assertion macros used by the serial line PWM configurator controller
`ifndef SERIAL_LINE_PWM_CONFIGURATOR_DEFINES_SVH
`define SERIAL_LINE_PWM_CONFIGURATOR_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SLPC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("slpc: same-cycle check failed");

// next-cycle implication, checked outside reset
`define SLPC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("slpc: next-cycle check failed");

`endif

[rtl/core/slpc_pkg.sv]
// Types and constants of the serial line PWM configurator
package slpc_pkg;

  localparam logic [7:0] CH_CR   = 8'd13;
  localparam logic [7:0] CH_BS   = 8'd8;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  localparam int unsigned NUM_W = 24;
  localparam logic [NUM_W-1:0] NUM_SAT = 24'hFFFFFF;

  localparam int unsigned CNT_W  = 20;
  localparam int unsigned DUTY_W = 7;
  localparam int unsigned STS_W  = 3;

  localparam logic [CNT_W-1:0]  TICKS_PER_SEC = 20'd1000000;
  localparam logic [CNT_W-1:0]  PCT_DIV       = 20'd100;
  localparam logic [CNT_W-1:0]  PERIOD_RST    = 20'd1000000;
  localparam logic [CNT_W-1:0]  PULSE_RST     = 20'd500000;
  localparam logic [DUTY_W-1:0] DUTY_RST      = 7'd50;

  // period / 100 as (period * PCT_RECIP) >> PCT_SHIFT, exact for any 20-bit period
  localparam int unsigned PCT_SHIFT = 27;
  localparam logic [20:0] PCT_RECIP = 21'd1342178;

  localparam logic [STS_W-1:0] ST_FREQ_SEL = 3'd0;
  localparam logic [STS_W-1:0] ST_DUTY_SEL = 3'd1;
  localparam logic [STS_W-1:0] ST_FREQ_SET = 3'd2;
  localparam logic [STS_W-1:0] ST_DUTY_SET = 3'd3;
  localparam logic [STS_W-1:0] ST_INVALID  = 3'd4;

  typedef struct packed {
    logic             store;
    logic             unstore;
    logic             parse_start;
    logic             rd;
    logic             acc;
    logic             clear_line;
    logic             div_freq;
    logic             div_pulse;
    logic             set_period;
    logic             set_duty;
    logic             set_pulse;
    logic             load_out;
    logic [STS_W-1:0] status;
  } slpc_cmd_t;

  typedef struct packed {
    logic is_bs;
    logic is_cr;
    logic line_end;
    logic num_ok;
    logic num_eq1;
    logic num_eq2;
    logic freq_ok;
    logic duty_ok;
    logic div_busy;
  } slpc_sts_t;

endpackage

[rtl/core/slpc_div.sv]
// Restoring divider, one quotient bit per cycle
module slpc_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [slpc_pkg::CNT_W-1:0]  dividend_i,
  input  logic [slpc_pkg::CNT_W-1:0]  divisor_i,
  output logic                        busy_o,
  output logic [slpc_pkg::CNT_W-1:0]  quotient_o
);

  localparam int unsigned W    = slpc_pkg::CNT_W;
  localparam int unsigned STPW = $clog2(W + 1);

  logic [STPW-1:0] step_q, step_d;
  logic [W-1:0]    rem_q, rem_d;
  logic [W-1:0]    quo_q, quo_d;
  logic [W-1:0]    dvs_q, dvs_d;
  logic [W:0]      shifted;
  logic            fits;

  assign shifted = {rem_q, quo_q[W-1]};
  assign fits    = shifted >= {1'b0, dvs_q};

  always_comb begin
    step_d = step_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      step_d = STPW'(W);
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (step_q != '0) begin
      step_d = step_q - 1'b1;
      rem_d  = fits ? W'(shifted - {1'b0, dvs_q}) : shifted[W-1:0];
      quo_d  = {quo_q[W-2:0], fits};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else begin
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign busy_o     = step_q != '0;
  assign quotient_o = quo_q;

endmodule

[rtl/core/slpc_dp.sv]
// Datapath: line store, decimal parser, settings and result register
module slpc_dp #(
  parameter int unsigned LINE_MAX = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [7:0]                    rx_byte_i,
  input  slpc_pkg::slpc_cmd_t           cmd_i,
  output slpc_pkg::slpc_sts_t           sts_o,
  output logic [slpc_pkg::STS_W-1:0]    status_o,
  output logic [slpc_pkg::CNT_W-1:0]    period_count_o,
  output logic [slpc_pkg::CNT_W-1:0]    pulse_count_o,
  output logic [slpc_pkg::DUTY_W-1:0]   duty_percent_o
);

  localparam int unsigned CW  = $clog2(LINE_MAX + 1);
  localparam int unsigned IW  = $clog2(LINE_MAX);
  localparam int unsigned NW  = slpc_pkg::NUM_W;
  localparam int unsigned W   = slpc_pkg::CNT_W;
  localparam int unsigned DW  = slpc_pkg::DUTY_W;
  localparam int unsigned PPW = W + $bits(slpc_pkg::PCT_RECIP);

  logic [7:0]    line_mem [LINE_MAX];
  logic [7:0]    rd_q;
  logic [CW-1:0] count_q, idx_q;
  logic          ovf_q, bad_q;
  logic [NW-1:0] acc_q;
  logic [W-1:0]  period_q, pulse_q;
  logic [DW-1:0] duty_q;
  logic [W-1:0]  pct_q;

  localparam int unsigned STS_W_L = slpc_pkg::STS_W;
  logic [STS_W_L-1:0] out_status_q;
  logic [W-1:0]  out_period_q, out_pulse_q;
  logic [DW-1:0] out_duty_q;

  logic           is_digit;
  logic [3:0]     digit;
  logic [27:0]    acc_next;
  logic           div_start, div_busy;
  logic [W-1:0]   div_dividend, div_divisor, quotient;
  logic [PPW-1:0] pct_prod;
  logic [26:0]    pulse_prod;

  assign is_digit = rd_q inside {[slpc_pkg::CH_ZERO:slpc_pkg::CH_NINE]};
  assign digit    = 4'(rd_q - slpc_pkg::CH_ZERO);
  assign acc_next = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + {24'b0, digit};

  always_ff @(posedge clk_i) begin
    if (cmd_i.store && count_q != CW'(LINE_MAX)) begin
      line_mem[count_q[IW-1:0]] <= rx_byte_i;
    end
    if (cmd_i.rd) begin
      rd_q <= line_mem[idx_q[IW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else if (cmd_i.clear_line) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else if (cmd_i.store) begin
      if (count_q != CW'(LINE_MAX)) begin
        count_q <= count_q + 1'b1;
      end else begin
        ovf_q <= 1'b1;
      end
    end else if (cmd_i.unstore && count_q != '0) begin
      count_q <= count_q - 1'b1;
    end
  end

  // parse the stored line, saturating the value
  always_ff @(posedge clk_i) begin
    if (cmd_i.parse_start) begin
      idx_q <= '0;
      acc_q <= '0;
      bad_q <= ovf_q;
    end else if (cmd_i.acc) begin
      idx_q <= idx_q + 1'b1;
      bad_q <= bad_q | !is_digit;
      acc_q <= (acc_next > {4'b0, slpc_pkg::NUM_SAT}) ? slpc_pkg::NUM_SAT : acc_next[NW-1:0];
    end
  end

  assign div_start    = cmd_i.div_freq;
  assign div_dividend = slpc_pkg::TICKS_PER_SEC;
  assign div_divisor  = acc_q[W-1:0];

  slpc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .quotient_o (quotient)
  );

  // scale the period down to one percent into a register, then weight it by the duty in the next cycle
  assign pct_prod   = PPW'(period_q) * PPW'(slpc_pkg::PCT_RECIP);
  assign pulse_prod = 27'(pct_q) * 27'(duty_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_pulse) begin
      pct_q <= W'(pct_prod[PPW-1:slpc_pkg::PCT_SHIFT]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= slpc_pkg::PERIOD_RST;
      pulse_q  <= slpc_pkg::PULSE_RST;
      duty_q   <= slpc_pkg::DUTY_RST;
    end else begin
      if (cmd_i.set_period) period_q <= quotient;
      if (cmd_i.set_duty)   duty_q   <= acc_q[DW-1:0];
      if (cmd_i.set_pulse)  pulse_q  <= pulse_prod[W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_status_q <= cmd_i.status;
      out_period_q <= period_q;
      out_pulse_q  <= pulse_q;
      out_duty_q   <= duty_q;
    end
  end

  always_comb begin
    sts_o.is_bs    = rx_byte_i == slpc_pkg::CH_BS;
    sts_o.is_cr    = rx_byte_i == slpc_pkg::CH_CR;
    sts_o.line_end = idx_q == count_q;
    sts_o.num_ok   = !bad_q;
    sts_o.num_eq1  = acc_q == NW'(1);
    sts_o.num_eq2  = acc_q == NW'(2);
    sts_o.freq_ok  = acc_q != '0 && acc_q <= {4'b0, slpc_pkg::TICKS_PER_SEC};
    sts_o.duty_ok  = acc_q <= NW'(100);
    sts_o.div_busy = div_busy;
  end

  assign status_o       = out_status_q;
  assign period_count_o = out_period_q;
  assign pulse_count_o  = out_pulse_q;
  assign duty_percent_o = out_duty_q;

endmodule

[rtl/core/slpc_ctrl.sv]
// Controller: byte handling, line parse sequencing and setting updates
`include "serial_line_pwm_configurator_defines.svh"

module slpc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  slpc_pkg::slpc_sts_t  sts_i,
  output slpc_pkg::slpc_cmd_t  cmd_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_RD     = 4'd1;
  localparam logic [3:0] S_ACC    = 4'd2;
  localparam logic [3:0] S_DECIDE = 4'd3;
  localparam logic [3:0] S_DIVF   = 4'd4;
  localparam logic [3:0] S_PSTART = 4'd5;
  localparam logic [3:0] S_DIVP   = 4'd6;
  localparam logic [3:0] S_OUT    = 4'd7;

  logic [3:0]                 state_q, state_d;
  logic                       await_q, await_d;
  logic                       sel_q, sel_d;
  logic [slpc_pkg::STS_W-1:0] status_q, status_d;
  logic                       out_valid_q, out_valid_d;
  logic                       in_accept, out_free;

  assign in_stall_o = state_q != S_IDLE;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    await_d     = await_q;
    sel_d       = sel_q;
    status_d    = status_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    cmd_o.status = status_q;
    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          if (sts_i.is_bs) begin
            cmd_o.unstore = 1'b1;
          end else if (sts_i.is_cr) begin
            cmd_o.parse_start = 1'b1;
            state_d = S_RD;
          end else begin
            cmd_o.store = 1'b1;
          end
        end
      end
      S_RD: begin
        if (sts_i.line_end) begin
          state_d = S_DECIDE;
        end else begin
          cmd_o.rd = 1'b1;
          state_d = S_ACC;
        end
      end
      S_ACC: begin
        cmd_o.acc = 1'b1;
        state_d = S_RD;
      end
      S_DECIDE: begin
        cmd_o.clear_line = 1'b1;
        status_d = slpc_pkg::ST_INVALID;
        state_d  = S_OUT;
        if (!await_q) begin
          if (sts_i.num_ok && sts_i.num_eq1) begin
            sel_d    = 1'b0;
            await_d  = 1'b1;
            status_d = slpc_pkg::ST_FREQ_SEL;
          end else if (sts_i.num_ok && sts_i.num_eq2) begin
            sel_d    = 1'b1;
            await_d  = 1'b1;
            status_d = slpc_pkg::ST_DUTY_SEL;
          end
        end else begin
          await_d = 1'b0;
          if (!sel_q) begin
            if (sts_i.num_ok && sts_i.freq_ok) begin
              cmd_o.div_freq = 1'b1;
              status_d = slpc_pkg::ST_FREQ_SET;
              state_d  = S_DIVF;
            end
          end else if (sts_i.num_ok && sts_i.duty_ok) begin
            cmd_o.set_duty = 1'b1;
            status_d = slpc_pkg::ST_DUTY_SET;
            state_d  = S_PSTART;
          end
        end
      end
      S_DIVF: begin
        if (!sts_i.div_busy) begin
          cmd_o.set_period = 1'b1;
          state_d = S_PSTART;
        end
      end
      S_PSTART: begin
        cmd_o.div_pulse = 1'b1;
        state_d = S_DIVP;
      end
      S_DIVP: begin
        cmd_o.set_pulse = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        // hold until the result register is free
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      await_q     <= 1'b0;
      sel_q       <= 1'b0;
      status_q    <= slpc_pkg::ST_FREQ_SEL;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      await_q     <= await_d;
      sel_q       <= sel_d;
      status_q    <= status_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `SLPC_ASSERT_NEXT(a_cr_starts_parse, in_accept && sts_i.is_cr, state_q == S_RD)
  `SLPC_ASSERT_NEXT(a_div_started, cmd_o.div_freq, sts_i.div_busy)
  `SLPC_ASSERT_NOW(a_load_needs_slot, cmd_o.load_out, !out_valid_q || !out_stall_i)
  `SLPC_ASSERT_NEXT(a_choice_arms_value,
                    state_q == S_DECIDE && !await_q && sts_i.num_ok && sts_i.num_eq1,
                    await_q && !sel_q)

endmodule

[rtl/core/serial_line_pwm_configurator.sv]
// Sequence: a non-CR byte is stored or erased in the idle state; a CR reads and parses each
// stored char, decides, then runs a duty update or a frequency update (20-step divider).
// Throughput: one byte per cycle between lines; one line in flight at a time.
// The result register holds one finished transaction while the next line is collected.
// Reset (async, active low): empty line, awaiting choice, frequency selected,
// period 1000000, pulse 500000, duty 50; line store contents are not cleared.
module serial_line_pwm_configurator #(
  parameter int unsigned LINE_MAX = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [7:0]                   rx_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [slpc_pkg::STS_W-1:0]   status_o,
  output logic [slpc_pkg::CNT_W-1:0]   period_count_o,
  output logic [slpc_pkg::CNT_W-1:0]   pulse_count_o,
  output logic [slpc_pkg::DUTY_W-1:0]  duty_percent_o
);

  slpc_pkg::slpc_cmd_t cmd;
  slpc_pkg::slpc_sts_t sts;

  slpc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  slpc_dp #(
    .LINE_MAX (LINE_MAX)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .rx_byte_i      (rx_byte_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .status_o       (status_o),
    .period_count_o (period_count_o),
    .pulse_count_o  (pulse_count_o),
    .duty_percent_o (duty_percent_o)
  );

endmodule

[dv/tb_serial_line_pwm_configurator.sv]
// Testbench for the serial line PWM configurator: byte stream in, PWM settings checked out
module tb_serial_line_pwm_configurator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LINE_LEN   = 16;
  localparam int unsigned RAND_BYTES = 1800;
  localparam int unsigned DRAIN_STEP = 350;
  localparam int unsigned HOLD_AT    = 600;
  localparam int unsigned HOLD_LEN   = 400;
  localparam int unsigned TAIL_CYC   = 120;
  // quiet stretch allowed: long hold-off plus a full-line frequency update plus a sender gap
  localparam int unsigned IDLE_LIMIT = 4000;
  localparam int unsigned MAX_SHOWN  = 10;
  localparam int unsigned DIR_ROWS   = 26;

  localparam int unsigned SW  = slpc_pkg::STS_W;
  localparam int unsigned CW  = slpc_pkg::CNT_W;
  localparam int unsigned DWD = slpc_pkg::DUTY_W;

  localparam logic [7:0] DIG1 = slpc_pkg::CH_ZERO + 8'd1;
  localparam logic [7:0] DIG2 = slpc_pkg::CH_ZERO + 8'd2;
  localparam logic [7:0] DIG7 = slpc_pkg::CH_ZERO + 8'd7;

  typedef struct packed {
    logic [SW-1:0]  status;
    logic [CW-1:0]  period;
    logic [CW-1:0]  pulse;
    logic [DWD-1:0] duty;
  } pwm_result_t;

  typedef struct packed {
    logic [7:0]  rx;
    logic        fixed;
    pwm_result_t res;
  } stim_row_t;

  localparam pwm_result_t NO_RES = '0;

  logic           clk       = 1'b0;
  logic           rst_n     = 1'b0;
  logic           in_valid  = 1'b0;
  logic           in_stall;
  logic [7:0]     rx_byte   = 8'd0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  logic [SW-1:0]  status;
  logic [CW-1:0]  period_count;
  logic [CW-1:0]  pulse_count;
  logic [DWD-1:0] duty_percent;

  serial_line_pwm_configurator #(.LINE_MAX(LINE_LEN)) dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .rx_byte_i      (rx_byte),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .status_o       (status),
    .period_count_o (period_count),
    .pulse_count_o  (pulse_count),
    .duty_percent_o (duty_percent)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow of the block's line and PWM state
  logic [7:0]     ln_buf [LINE_LEN];
  int unsigned    ln_len      = 0;
  bit             ln_ovf      = 1'b0;
  bit             want_value  = 1'b0;
  bit             duty_chosen = 1'b0;
  logic [CW-1:0]  cur_period  = slpc_pkg::PERIOD_RST;
  logic [CW-1:0]  cur_pulse   = slpc_pkg::PULSE_RST;
  logic [DWD-1:0] cur_duty    = slpc_pkg::DUTY_RST;

  pwm_result_t pending [$];
  int unsigned mismatches   = 0;
  int unsigned bytes_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned status_hits [slpc_pkg::ST_INVALID+1];
  int unsigned burst_left   = 0;
  int unsigned hold_reqs    = 0;
  int unsigned hold_seen    = 0;
  int unsigned hold_left    = 0;
  int unsigned quiet        = 0;
  logic [31:0] rx_cyc       = '0;

  stim_row_t dir_tab [DIR_ROWS] = '{
    '{slpc_pkg::CH_CR,   1'b1, '{slpc_pkg::ST_INVALID,  20'd1000000, 20'd500000,  7'd50}},
    '{slpc_pkg::CH_BS,   1'b0, NO_RES},
    '{DIG2,              1'b0, NO_RES},
    '{slpc_pkg::CH_CR,   1'b1, '{slpc_pkg::ST_DUTY_SEL, 20'd1000000, 20'd500000,  7'd50}},
    '{DIG1,              1'b0, NO_RES},
    '{slpc_pkg::CH_ZERO, 1'b0, NO_RES},
    '{slpc_pkg::CH_ZERO, 1'b0, NO_RES},
    '{slpc_pkg::CH_CR,   1'b1, '{slpc_pkg::ST_DUTY_SET, 20'd1000000, 20'd1000000, 7'd100}},
    '{DIG1,              1'b0, NO_RES},
    '{slpc_pkg::CH_CR,   1'b1, '{slpc_pkg::ST_FREQ_SEL, 20'd1000000, 20'd1000000, 7'd100}},
    '{DIG1,              1'b0, NO_RES},
    '{slpc_pkg::CH_ZERO, 1'b0, NO_RES},
    '{slpc_pkg::CH_ZERO, 1'b0, NO_RES},
    '{slpc_pkg::CH_ZERO, 1'b0, NO_RES},
    '{slpc_pkg::CH_ZERO, 1'b0, NO_RES},
    '{slpc_pkg::CH_ZERO, 1'b0, NO_RES},
    '{slpc_pkg::CH_ZERO, 1'b0, NO_RES},
    '{slpc_pkg::CH_CR,   1'b1, '{slpc_pkg::ST_FREQ_SET, 20'd1,       20'd0,       7'd100}},
    '{8'h00,             1'b0, NO_RES},
    '{8'hFF,             1'b0, NO_RES},
    '{slpc_pkg::CH_CR,   1'b1, '{slpc_pkg::ST_INVALID,  20'd1,       20'd0,       7'd100}},
    '{DIG2,              1'b0, NO_RES},
    '{DIG7,              1'b0, NO_RES},
    '{slpc_pkg::CH_BS,   1'b0, NO_RES},
    '{slpc_pkg::CH_CR,   1'b0, NO_RES},
    '{slpc_pkg::CH_CR,   1'b0, NO_RES}
  };

  // Advance the shadow state by one byte; returns 1 when a line ends
  function automatic bit pwm_predict(input logic [7:0] b, output pwm_result_t r);
    int unsigned   acc;
    int unsigned   k;
    bit            ok;
    logic [SW-1:0] st;
    r = NO_RES;
    if (b == slpc_pkg::CH_BS) begin
      if (ln_len != 0) ln_len--;
      return 1'b0;
    end
    if (b != slpc_pkg::CH_CR) begin
      if (ln_len < LINE_LEN) begin
        ln_buf[ln_len] = b;
        ln_len++;
      end else begin
        ln_ovf = 1'b1;
      end
      return 1'b0;
    end
    ok = !ln_ovf;
    acc = 0;
    for (k = 0; k < ln_len; k++) begin
      if (ln_buf[k] < slpc_pkg::CH_ZERO || ln_buf[k] > slpc_pkg::CH_NINE) begin
        ok = 1'b0;
      end else begin
        acc = acc * 10 + (ln_buf[k] - slpc_pkg::CH_ZERO);
        if (acc > slpc_pkg::NUM_SAT) acc = slpc_pkg::NUM_SAT;
      end
    end
    ln_len = 0;
    ln_ovf = 1'b0;
    st = slpc_pkg::ST_INVALID;
    if (!want_value) begin
      if (ok && acc == 1) begin
        duty_chosen = 1'b0;
        want_value  = 1'b1;
        st = slpc_pkg::ST_FREQ_SEL;
      end else if (ok && acc == 2) begin
        duty_chosen = 1'b1;
        want_value  = 1'b1;
        st = slpc_pkg::ST_DUTY_SEL;
      end
    end else begin
      want_value = 1'b0;
      if (!duty_chosen) begin
        if (ok && acc >= 1 && acc <= slpc_pkg::TICKS_PER_SEC) begin
          cur_period = CW'(slpc_pkg::TICKS_PER_SEC / acc);
          cur_pulse  = (cur_period / slpc_pkg::PCT_DIV) * cur_duty;
          st = slpc_pkg::ST_FREQ_SET;
        end
      end else if (ok && acc <= slpc_pkg::PCT_DIV) begin
        cur_pulse = CW'((cur_period / slpc_pkg::PCT_DIV) * acc);
        cur_duty  = DWD'(acc);
        st = slpc_pkg::ST_DUTY_SET;
      end
    end
    r = '{st, cur_period, cur_pulse, cur_duty};
    return 1'b1;
  endfunction

  // Offer one byte, honoring the burst/gap pattern, and record what it should cause
  task automatic send_byte(input logic [7:0] b, input logic fixed = 1'b0,
                           input pwm_result_t fixed_res = '0);
    int unsigned gap;
    pwm_result_t pred;
    if (burst_left == 0) begin
      burst_left = $urandom_range(40, 1);
      case ($urandom_range(3))
        0, 1:    gap = 0;
        2:       gap = $urandom_range(6, 1);
        default: gap = $urandom_range(30, 7);
      endcase
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (in_stall !== 1'b0);
    bytes_sent++;
    if (pwm_predict(b, pred)) pending.push_back(fixed ? fixed_res : pred);
  endtask

  // Type a line; now and then slip in a stray character and erase it again
  task automatic send_line(input string body);
    int unsigned i;
    logic [7:0]  junk;
    for (i = 0; i < body.len(); i++) begin
      if ($urandom_range(19) == 0) begin
        junk = 8'($urandom_range(255));
        if (junk == slpc_pkg::CH_CR || junk == slpc_pkg::CH_BS) junk = slpc_pkg::CH_NINE;
        send_byte(junk);
        send_byte(slpc_pkg::CH_BS);
      end
      send_byte(body[i]);
    end
    send_byte(slpc_pkg::CH_CR);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    @(posedge clk);
    burst_left = 0;
  endtask

  function automatic string long_digits();
    string       s;
    int unsigned n;
    int unsigned i;
    s = "";
    n = $urandom_range(LINE_LEN, 8);
    for (i = 0; i < n; i++) s = {s, $sformatf("%0d", $urandom_range(9))};
    return s;
  endfunction

  function automatic string freq_text();
    case ($urandom_range(9))
      0:       return "1";
      1:       return "1000000";
      2:       return "0";
      3:       return $sformatf("%0d", $urandom_range(2000000, 1000001));
      4:       return long_digits();
      5, 6:    return $sformatf("%0d", $urandom_range(100, 1));
      default: return $sformatf("%0d", $urandom_range(1000000, 1));
    endcase
  endfunction

  function automatic string duty_text();
    case ($urandom_range(7))
      0:       return "0";
      1:       return "100";
      2:       return $sformatf("%0d", $urandom_range(999, 101));
      3:       return long_digits();
      default: return $sformatf("%0d", $urandom_range(100));
    endcase
  endfunction

  task automatic note_mismatch(input string what, input pwm_result_t want,
                               input pwm_result_t got);
    mismatches++;
    if (mismatches <= MAX_SHOWN)
      $display("%0t %s: want st=%0d per=%0d pul=%0d duty=%0d, got st=%0d per=%0d pul=%0d duty=%0d",
               $realtime, what, want.status, want.period, want.pulse, want.duty,
               got.status, got.period, got.pulse, got.duty);
  endtask

  // Result side: check each transaction, then pick the next stall value
  always @(posedge clk) begin
    pwm_result_t got;
    pwm_result_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got = '{status, period_count, pulse_count, duty_percent};
        results_seen++;
        if (got.status <= slpc_pkg::ST_INVALID) status_hits[got.status]++;
        if (pending.size() == 0) begin
          note_mismatch("unexpected result", NO_RES, got);
        end else begin
          want = pending.pop_front();
          if (got.status !== want.status || got.period !== want.period ||
              got.pulse !== want.pulse || got.duty !== want.duty)
            note_mismatch("result mismatch", want, got);
        end
      end
      rx_cyc <= rx_cyc + 1;
      if (hold_seen != hold_reqs) begin
        hold_seen <= hold_reqs;
        hold_left <= HOLD_LEN;
        out_stall <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        case (rx_cyc[9:8])
          2'd0:    out_stall <= 1'b0;
          2'd1:    out_stall <= ($urandom_range(99) < 30);
          2'd2:    out_stall <= ($urandom_range(99) < 80);
          default: out_stall <= ((rx_cyc % 5) < 2);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet <= 0;
      end else if (quiet >= IDLE_LIMIT) begin
        $display("tb_serial_line_pwm_configurator: FAIL");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  initial begin
    int unsigned i;
    int unsigned n;
    int unsigned pick;
    int unsigned next_drain;
    bit          use_freq;
    bit          hold_done;
    logic [7:0]  b;
    string       s;
    foreach (status_hits[i]) status_hits[i] = 0;
    next_drain = DIR_ROWS + DRAIN_STEP;
    hold_done  = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) send_byte(dir_tab[i].rx, dir_tab[i].fixed, dir_tab[i].res);
    drain_results();

    while (bytes_sent < DIR_ROWS + RAND_BYTES) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        // well-formed choice, then a value that may be out of range
        use_freq = $urandom_range(1);
        s = use_freq ? "1" : "2";
        if ($urandom_range(5) == 0) s = {"0", s};
        send_line(s);
        send_line(use_freq ? freq_text() : duty_text());
      end else if (pick < 78) begin
        // overrun the line store, then back off a little
        n = $urandom_range(LINE_LEN + 8, LINE_LEN + 1);
        for (i = 0; i < n; i++) send_byte(8'(slpc_pkg::CH_ZERO + $urandom_range(9)));
        n = $urandom_range(6);
        for (i = 0; i < n; i++) send_byte(slpc_pkg::CH_BS);
        send_byte(slpc_pkg::CH_CR);
      end else if (pick < 90) begin
        n = $urandom_range(8);
        for (i = 0; i < n; i++) begin
          b = 8'($urandom_range(255));
          send_byte(b);
        end
        send_byte(slpc_pkg::CH_CR);
      end else if (pick < 95) begin
        send_line($sformatf("%0d", $urandom_range(1) ? 0 : $urandom_range(99, 3)));
      end else begin
        send_byte(slpc_pkg::CH_BS);
        send_byte(slpc_pkg::CH_BS);
        send_byte(slpc_pkg::CH_CR);
      end

      if (!hold_done && bytes_sent >= HOLD_AT) begin
        // hold the result side off while bytes keep coming
        hold_reqs <= hold_reqs + 1;
        hold_done = 1'b1;
      end else if (bytes_sent >= next_drain) begin
        drain_results();
        next_drain = bytes_sent + DRAIN_STEP;
      end
    end

    drain_results();
    repeat (TAIL_CYC) @(posedge clk);
    $display("Sent %0d bytes, checked %0d line results (%0d mismatches).",
             bytes_sent, results_seen, mismatches);
    $display("By status: freq chosen %0d, duty chosen %0d, freq set %0d,",
             status_hits[slpc_pkg::ST_FREQ_SEL], status_hits[slpc_pkg::ST_DUTY_SEL],
             status_hits[slpc_pkg::ST_FREQ_SET]);
    $display("  duty set %0d, invalid %0d",
             status_hits[slpc_pkg::ST_DUTY_SET], status_hits[slpc_pkg::ST_INVALID]);
    if (mismatches == 0) begin
      $display("tb_serial_line_pwm_configurator: PASS");
    end else begin
      $display("tb_serial_line_pwm_configurator: FAIL");
    end
    $finish;
  end

endmodule
